/* rtl/core/tem_pkg.sv */
// Package for the text extent measurement block: widths, glyph entry type,
// queue operation type and shared constants. No dependencies.
`timescale 1ns / 1ps

package tem_pkg;

  // Glyph table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Stream widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;

  // Field widths
  localparam int CP_W    = 21;
  localparam int SUM_W   = 24;
  localparam int HGT_W   = 10;
  localparam int CNT_W   = 16;
  localparam int GW_W    = 11;
  localparam int PAD_W   = 10;
  localparam int CONTR_W = 13;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic {
    OP_LOAD,
    OP_TEXT
  } op_kind_e;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_ANGULAR = 2'd1,
    MODE_NONE    = 2'd2
  } mode_e;

  // One glyph table entry, raw two's complement bits
  typedef struct packed {
    logic [GW_W-1:0]  w;
    logic [GW_W-1:0]  h;
    logic [PAD_W-1:0] lp;
    logic [PAD_W-1:0] rp;
    logic [PAD_W-1:0] alp;
    logic [PAD_W-1:0] arp;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  // Reset contents: width and height absent, pads zero
  localparam glyph_t GLYPH_CLEAR = '{w: '1, h: '1, lp: '0, rp: '0, alp: '0, arp: '0};

  // Operation handed from the front to the back
  typedef struct packed {
    op_kind_e         kind;
    logic [IDX_W-1:0] addr;     // write address or lookup address
    glyph_t           entry;    // load data
    logic             cp_valid; // a codepoint completed on this byte
    logic             cp_hit;   // codepoint lies inside the table
    logic [1:0]       mode;
    logic             last;
    logic             trunc;
  } op_t;

endpackage

/* rtl/core/tem_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tem_front.sv */
// Front end: accepts stream transactions, decodes UTF-8 bytes and classifies
// each item into a queue operation. Depends on tem_pkg.
`timescale 1ns / 1ps

module tem_front
  import tem_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 in_last_i,
  input  logic                 in_user_i,
  input  logic                 init_done_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output op_t                  push_op_o
);

  logic [1:0]      pending_q, pending_d;
  logic [CP_W-1:0] accum_q, accum_d;

  logic [7:0]      text_byte;
  logic [1:0]      mode;
  logic [9:0]      entry_index;
  glyph_t          entry;
  logic            accept;
  logic            complete;
  logic [CP_W-1:0] cp;
  logic [1:0]      pend_nxt;
  logic [CP_W-1:0] acc_nxt;
  logic [31:0]     idx_ext;
  logic [31:0]     cp_ext;
  logic            load_ok;

  // field unpacking
  assign text_byte   = in_data_i[7:0];
  assign mode        = in_data_i[9:8];
  assign entry_index = in_data_i[19:10];
  assign entry.w     = in_data_i[30:20];
  assign entry.h     = in_data_i[41:31];
  assign entry.lp    = in_data_i[51:42];
  assign entry.rp    = in_data_i[61:52];
  assign entry.alp   = in_data_i[71:62];
  assign entry.arp   = in_data_i[81:72];

  assign in_ready_o = init_done_i && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // UTF-8 decode, no validity checks
  always_comb begin
    complete = 1'b0;
    pend_nxt = pending_q;
    acc_nxt  = accum_q;
    cp       = '0;
    if (pending_q != 2'd0) begin
      acc_nxt  = {accum_q[CP_W-7:0], text_byte[5:0]};
      pend_nxt = pending_q - 2'd1;
      complete = (pend_nxt == 2'd0);
      cp       = acc_nxt;
    end else if (text_byte[7:5] == 3'b110) begin
      acc_nxt  = CP_W'(text_byte[4:0]);
      pend_nxt = 2'd1;
    end else if (text_byte[7:4] == 4'b1110) begin
      acc_nxt  = CP_W'(text_byte[3:0]);
      pend_nxt = 2'd2;
    end else if (text_byte[7:3] == 5'b11110) begin
      acc_nxt  = CP_W'(text_byte[2:0]);
      pend_nxt = 2'd3;
    end else begin
      complete = 1'b1;
      cp       = CP_W'(text_byte);
    end
  end

  assign idx_ext = 32'(entry_index);
  assign cp_ext  = 32'(cp);
  assign load_ok = idx_ext < 32'(TABLE_DEPTH);

  // operation build
  always_comb begin
    push_op_o          = '0;
    push_op_o.mode     = mode;
    push_op_o.last     = in_last_i;
    push_op_o.trunc    = (pend_nxt != 2'd0);
    push_op_o.cp_valid = complete;
    push_op_o.cp_hit   = cp_ext < 32'(TABLE_DEPTH);
    push_op_o.entry    = entry;
    if (in_user_i) begin
      push_op_o.kind = OP_TEXT;
      push_op_o.addr = cp_ext[IDX_W-1:0];
    end else begin
      push_op_o.kind = OP_LOAD;
      push_op_o.addr = idx_ext[IDX_W-1:0];
    end
  end

  assign push_o = accept && (in_user_i ? (complete || in_last_i) : load_ok);

  // decoder state, cleared at the end of each string
  always_comb begin
    pending_d = pending_q;
    accum_d   = accum_q;
    if (accept && in_user_i) begin
      if (in_last_i) begin
        pending_d = 2'd0;
        accum_d   = '0;
      end else begin
        pending_d = pend_nxt;
        accum_d   = acc_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
      accum_q   <= '0;
    end else begin
      pending_q <= pending_d;
      accum_q   <= accum_d;
    end
  end

endmodule

/* rtl/core/tem_fifo.sv */
// Short operation queue between front and back.
// Depends on tem_pkg.
`timescale 1ns / 1ps

module tem_fifo
  import tem_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  pop_op_o
);

  op_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o   = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wptr_d = do_push ? wptr_q + FIFO_AW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + FIFO_AW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (FIFO_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

/* rtl/core/tem_back.sv */
// Back end: glyph table, clearing pass, width/height/count accumulation and
// the result register. Depends on tem_pkg and tem_ram.
`timescale 1ns / 1ps

module tem_back
  import tem_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fifo_valid_i,
  input  op_t                   fifo_op_i,
  output logic                  pop_o,
  output logic                  init_done_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_user_o
);

  localparam logic [IDX_W:0] CLR_END = (IDX_W+1)'(TABLE_DEPTH);

  logic [IDX_W:0]     clr_cnt_q, clr_cnt_d;
  logic               clearing;
  logic               en;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  glyph_t             ram_wdata;
  glyph_t             ram_rdata;

  // stage A: table read in flight
  logic               a_valid_q;
  op_t                a_op_q;

  // stage B: contribution computed
  logic               b_valid_q;
  logic               b_add_q, b_hen_q, b_cnt_q, b_last_q, b_trunc_q;
  logic [CONTR_W-1:0] b_contr_q;
  logic [HGT_W-1:0]   b_hgt_q;

  logic               hit;
  logic [GW_W-1:0]    pad;
  logic [CONTR_W-1:0] contr;

  // accumulators
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [HGT_W-1:0]   hmax_q, hmax_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [SUM_W-1:0]   sum_nxt;
  logic [HGT_W-1:0]   hmax_nxt;
  logic [CNT_W-1:0]   cnt_nxt;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [SUM_W-1:0]   res_sum_q;
  logic [HGT_W-1:0]   res_hgt_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_trunc_q;

  assign clearing    = (clr_cnt_q != CLR_END);
  assign init_done_o = !clearing;
  assign clr_cnt_d   = clearing ? clr_cnt_q + (IDX_W+1)'(1) : clr_cnt_q;

  // whole back pipeline moves when the result register can take a value
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && fifo_valid_i;

  // table write port: clearing pass first, then load operations
  always_comb begin
    ram_we    = clearing || (pop_o && (fifo_op_i.kind == OP_LOAD));
    ram_waddr = clearing ? clr_cnt_q[IDX_W-1:0] : fifo_op_i.addr;
    ram_wdata = clearing ? GLYPH_CLEAR : fifo_op_i.entry;
  end

  tem_ram #(
    .WIDTH(GLYPH_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (en),
    .raddr_i(fifo_op_i.addr),
    .rdata_o(ram_rdata)
  );

  // pad select and glyph contribution
  always_comb begin
    hit = a_op_q.cp_valid && a_op_q.cp_hit;
    unique case (a_op_q.mode)
      MODE_LINEAR: begin
        pad = {ram_rdata.lp[PAD_W-1], ram_rdata.lp} + {ram_rdata.rp[PAD_W-1], ram_rdata.rp};
      end
      MODE_ANGULAR: begin
        pad = {ram_rdata.alp[PAD_W-1], ram_rdata.alp}
            + {ram_rdata.arp[PAD_W-1], ram_rdata.arp};
      end
      default: begin
        pad = '0;
      end
    endcase
    contr = {{2{ram_rdata.w[GW_W-1]}}, ram_rdata.w} + {{2{pad[GW_W-1]}}, pad};
  end

  // saturating accumulate
  always_comb begin
    sum_wide = {sum_q[SUM_W-1], sum_q}
             + {{(SUM_W+1-CONTR_W){b_contr_q[CONTR_W-1]}}, b_contr_q};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    sum_nxt  = b_add_q ? sum_sat : sum_q;
    hmax_nxt = (b_hen_q && (b_hgt_q > hmax_q)) ? b_hgt_q : hmax_q;
    cnt_nxt  = (b_cnt_q && (cnt_q != CNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;

    sum_d       = sum_q;
    hmax_d      = hmax_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (en) begin
      out_valid_d = b_valid_q && b_last_q;
      if (b_valid_q) begin
        if (b_last_q) begin
          sum_d  = '0;
          hmax_d = '0;
          cnt_d  = '0;
        end else begin
          sum_d  = sum_nxt;
          hmax_d = hmax_nxt;
          cnt_d  = cnt_nxt;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      hmax_q      <= '0;
      cnt_q       <= '0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      hmax_q      <= hmax_d;
      cnt_q       <= cnt_d;
      if (en) begin
        a_valid_q <= pop_o && (fifo_op_i.kind == OP_TEXT);
        b_valid_q <= a_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q    <= fifo_op_i;
      b_add_q   <= hit && !ram_rdata.w[GW_W-1];
      b_hen_q   <= hit && !ram_rdata.h[GW_W-1];
      b_hgt_q   <= ram_rdata.h[HGT_W-1:0];
      b_contr_q <= contr;
      b_cnt_q   <= a_op_q.cp_valid;
      b_last_q  <= a_op_q.last;
      b_trunc_q <= a_op_q.trunc;
      if (b_valid_q && b_last_q) begin
        res_sum_q   <= sum_nxt;
        res_hgt_q   <= hmax_nxt;
        res_cnt_q   <= cnt_nxt;
        res_trunc_q <= b_trunc_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W-SUM_W-HGT_W-CNT_W){1'b0}}, res_cnt_q, res_hgt_q, res_sum_q};
  assign out_user_o  = res_trunc_q;

endmodule

/* rtl/core/text_extent_measure.sv */
// Top level of the text extent measurement block: front decoder, operation
// queue and back end. Depends on tem_pkg, tem_front, tem_fifo, tem_back.
`timescale 1ns / 1ps
//
// Usage
//   Input stream s_axis: tuser selects the item kind (0 glyph table load,
//   1 text byte). A text byte with tlast set ends the string and yields one
//   result transaction on m_axis; loads and other bytes yield none.
//   Output m_axis: total width (saturating signed), largest height and
//   codepoint count (saturating); tuser flags a string that ended inside a
//   multibyte sequence.
//   Throughput: one input transaction per cycle while m_axis_tready_i is high.
//   Path: after the final byte is accepted the result passes the queue
//   register, the glyph table read port (stage A), the contribution register
//   (stage B) and the accumulate into the result register, where it is valid.
//   Reset: after rst_ni is released the glyph table is swept to its reset
//   contents, one entry per cycle, all TABLE_DEPTH (1024) entries; s_axis_tready_o
//   stays low during the sweep.
//   Stall: while m_axis_tready_i is low the result holds, the back end waits
//   and the four-entry queue keeps taking input until it fills, after which
//   s_axis_tready_o drops.
//
module text_extent_measure
  import tem_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // text_byte[7:0], measure_mode[9:8], entry_index[19:10], entry_width[30:20],
  // entry_height[41:31], entry_left_pad[51:42], entry_right_pad[61:52],
  // entry_angular_left_pad[71:62], entry_angular_right_pad[81:72], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,  // last_byte
  input  logic                  s_axis_tuser_i,  // func
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // run_width[23:0], peak_height[33:24], char_count[49:34], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o   // truncated
);

  logic push;
  op_t  push_op;
  logic fifo_full;
  logic fifo_valid;
  op_t  fifo_op;
  logic pop;
  logic init_done;

  tem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .in_user_i  (s_axis_tuser_i),
    .init_done_i(init_done),
    .fifo_full_i(fifo_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  tem_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .push_op_i(push_op),
    .full_o   (fifo_full),
    .pop_i    (pop),
    .valid_o  (fifo_valid),
    .pop_op_o (fifo_op)
  );

  tem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_valid_i(fifo_valid),
    .fifo_op_i   (fifo_op),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule

/* rtl/core/tem_checker.sv */
// Port-level checker for text_extent_measure, attached by bind.
// Depends on tem_pkg.
`timescale 1ns / 1ps

module tem_checker
  import tem_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  s_axis_tlast_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  logic [3:0] open_q;
  logic       end_in;
  logic       res_out;

  assign end_in  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i && s_axis_tlast_i;
  assign res_out = m_axis_tvalid_o && m_axis_tready_i;

  // strings ended but not yet reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + 4'(end_in) - 4'(res_out);
    end
  end

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // every result answers an accepted final byte
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> open_q != 4'd0)
    else $error("result without a final text byte");

  // a nonzero height needs at least one counted codepoint
  a_hgt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[33:24] != '0 |-> m_axis_tdata_o[49:34] != '0)
    else $error("height reported with zero count");

  // the table sweep blocks input right after reset
  a_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !s_axis_tready_o)
    else $error("input taken during table sweep");

endmodule

bind text_extent_measure tem_checker u_tem_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tlast_i (s_axis_tlast_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
